FILE: rtl/core/btk_pkg.sv
// Shared codes and widths for the bounded top-K heap selector.
package btk_pkg;
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [0:0] REG_CAPACITY   = 1'd0;
  localparam logic [0:0] REG_ORDER_MODE = 1'd1;

  localparam int CAP_WIDTH   = 9;
  localparam int INDEX_WIDTH = 8;
endpackage

FILE: rtl/core/btk_front.sv
// Front end: accepts input beats and queues them for the heap engine.
module btk_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            action,
  input  logic signed [DATA_WIDTH-1:0]          value,
  input  logic [btk_pkg::INDEX_WIDTH-1:0]       index,
  output logic                                  cmd_valid,
  input  logic                                  cmd_take,
  output logic [1:0]                            cmd_action,
  output logic [DATA_WIDTH-1:0]                 cmd_value,
  output logic [btk_pkg::INDEX_WIDTH-1:0]       cmd_index
);
  import btk_pkg::*;

  // two-entry queue
  logic [1:0]                  act_q [2];
  logic [DATA_WIDTH-1:0]       val_q [2];
  logic [INDEX_WIDTH-1:0]      idx_q [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        do_wr;
  logic                        do_rd;

  assign full  = (count == 2'd2);
  assign do_wr = push && !full;
  assign do_rd = cmd_take && (count != 2'd0);
  assign cmd_valid  = (count != 2'd0);
  assign cmd_action = act_q[rd_ptr];
  assign cmd_value  = val_q[rd_ptr];
  assign cmd_index  = idx_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      act_q[wr_ptr] <= action;
      val_q[wr_ptr] <= value;
      idx_q[wr_ptr] <= index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

FILE: rtl/core/btk_engine.sv
// Heap engine: store memory, append, heap build, replace-root and sift-down sequencer.
module btk_engine #(
  parameter int MAX_ENTRIES = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cmd_valid,
  output logic                                  cmd_take,
  input  logic [1:0]                            cmd_action,
  input  logic [DATA_WIDTH-1:0]                 cmd_value,
  input  logic [btk_pkg::INDEX_WIDTH-1:0]       cmd_index,
  input  logic [btk_pkg::CAP_WIDTH-1:0]         capacity,
  input  logic                                  order_mode,
  output logic                                  res_valid,
  input  logic                                  res_take,
  output logic [DATA_WIDTH-1:0]                 res_read_value,
  output logic [btk_pkg::CAP_WIDTH-1:0]         res_entry_count,
  output logic                                  res_kept,
  output logic                                  res_index_valid
);
  import btk_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = AW + 2;   // positions up to 2*MAX_ENTRIES
  localparam int CW = CAP_WIDTH > (AW + 1) ? CAP_WIDTH : AW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // capture read data
  localparam logic [3:0] S_BLD  = 4'd2;  // start next build sift or finish the build
  localparam logic [3:0] S_BRD  = 4'd3;  // read build start position
  localparam logic [3:0] S_BCAP = 4'd4;  // capture the value to sift
  localparam logic [3:0] S_ROOT = 4'd5;  // read root
  localparam logic [3:0] S_RCMP = 4'd6;  // decide replace
  localparam logic [3:0] S_SIFT = 4'd7;  // read left child, or place the value
  localparam logic [3:0] S_SL   = 4'd8;  // read right child, compare left
  localparam logic [3:0] S_SC   = 4'd9;  // compare right, promote a child or place

  logic [DATA_WIDTH-1:0] mem [MAX_ENTRIES];
  logic [DATA_WIDTH-1:0] rdata;
  logic [AW-1:0]         raddr;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;

  logic [3:0]            state;
  logic [CW-1:0]         held;
  logic                  built;
  logic                  in_build;
  logic [PW-1:0]         build_i;    // next build start + 1
  logic [PW-1:0]         pos;
  logic [PW-1:0]         pick;
  logic [DATA_WIDTH-1:0] pick_val;
  logic [DATA_WIDTH-1:0] cur;        // value being sifted, written only where it lands
  logic [DATA_WIDTH-1:0] new_val;
  logic [PW-1:0]         left;
  logic [CW-1:0]         k_eff;
  logic [PW-1:0]         held_p;
  logic                  append_go;
  logic                  need_heap;
  logic                  need_read;
  logic [CW-1:0]         count_after;
  logic                  right_wins;
  logic [PW-1:0]         pick_fin;
  logic [DATA_WIDTH-1:0] pick_val_fin;
  logic                  sift_end;

  function automatic logic beats(input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b,
                                 input logic mode);
    logic [DATA_WIDTH-1:0] ka;
    logic [DATA_WIDTH-1:0] kb;
    ka = {~a[DATA_WIDTH-1], a[DATA_WIDTH-2:0]};
    kb = {~b[DATA_WIDTH-1], b[DATA_WIDTH-2:0]};
    return mode ? (ka > kb) : (ka < kb);
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign k_eff = (CW'(capacity) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(capacity);
  assign left   = (pos << 1) + PW'(1);
  assign held_p = PW'(held);

  assign append_go   = (cmd_action == ACT_PUSH) && (k_eff != '0) && (held < k_eff);
  assign need_heap   = (cmd_action == ACT_PUSH) && (k_eff != '0) && (held >= k_eff);
  assign need_read   = (cmd_action == ACT_READ) && (CW'(cmd_index) < held);
  assign count_after = append_go ? held + CW'(1) :
                       (cmd_action == ACT_CLEAR) ? '0 : held;

  assign sift_end     = (pos >= held_p) || (left >= held_p);
  assign right_wins   = ((left + PW'(1)) < held_p) && beats(pick_val, rdata, order_mode);
  assign pick_fin     = right_wins ? left + PW'(1) : pick;
  assign pick_val_fin = right_wins ? rdata : pick_val;

  // read address by state
  always_comb begin
    case (state)
      S_BRD:   raddr = pos[AW-1:0];
      S_ROOT:  raddr = '0;
      S_SIFT:  raddr = left[AW-1:0];
      S_SL:    raddr = AW'(left + PW'(1));
      default: raddr = AW'(cmd_index);
    endcase
  end

  // write port: append, promote a child, or place the sifted value
  always_comb begin
    we    = 1'b0;
    waddr = pos[AW-1:0];
    wdata = cur;
    case (state)
      S_IDLE: begin
        if (cmd_take && append_go) begin
          we    = 1'b1;
          waddr = held[AW-1:0];
          wdata = cmd_value;
        end
      end
      S_SIFT: we = sift_end;
      S_SC: begin
        we    = 1'b1;
        wdata = (pick_fin == pos) ? cur : pick_val_fin;
      end
      default: we = 1'b0;
    endcase
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid && !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      built     <= 1'b0;
      in_build  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (res_valid && res_take) res_valid <= 1'b0;
          if (cmd_take) begin
            res_read_value  <= '0;
            res_index_valid <= 1'b0;
            res_kept        <= append_go;
            res_entry_count <= CAP_WIDTH'(count_after);
            new_val         <= cmd_value;
            if (append_go) held <= held + CW'(1);
            else if (cmd_action == ACT_CLEAR) begin
              held  <= '0;
              built <= 1'b0;
            end
            if (need_heap) begin
              if (built) state <= S_ROOT;
              else begin
                in_build <= 1'b1;
                build_i  <= PW'(k_eff >> 1);
                state    <= S_BLD;
              end
            end else if (need_read) state <= S_RD;
            else res_valid <= 1'b1;
          end
        end
        S_RD: begin
          res_read_value  <= rdata;
          res_index_valid <= 1'b1;
          res_valid       <= 1'b1;
          state           <= S_IDLE;
        end
        S_BLD: begin
          if (build_i == '0) begin
            in_build <= 1'b0;
            built    <= 1'b1;
            state    <= S_ROOT;
          end else begin
            pos     <= build_i - PW'(1);
            build_i <= build_i - PW'(1);
            state   <= S_BRD;
          end
        end
        S_BRD:  state <= S_BCAP;
        S_BCAP: begin
          cur   <= rdata;
          state <= S_SIFT;
        end
        S_ROOT: state <= S_RCMP;
        S_RCMP: begin
          if (beats(new_val, rdata, order_mode)) begin
            cur      <= new_val;
            pos      <= '0;
            res_kept <= 1'b1;
            state    <= S_SIFT;
          end else begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SIFT: begin
          if (sift_end) begin
            state <= in_build ? S_BLD : S_IDLE;
            if (!in_build) res_valid <= 1'b1;
          end else state <= S_SL;
        end
        S_SL: begin
          // rdata = left child
          if (beats(cur, rdata, order_mode)) begin
            pick     <= left;
            pick_val <= rdata;
          end else begin
            pick     <= pos;
            pick_val <= cur;
          end
          state <= S_SC;
        end
        S_SC: begin
          // rdata = right child
          if (pick_fin == pos) begin
            state <= in_build ? S_BLD : S_IDLE;
            if (!in_build) res_valid <= 1'b1;
          end else begin
            pos   <= pick_fin;
            state <= S_SIFT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/bounded_top_k_heap_selector.sv
// Append, clear, no-op, miss read and capacity-zero push set the result straight from idle;
// an in-range read goes through a memory read first; a push on a built heap reads the root
// and is dropped, or replaces the root and sifts down level by level.
// The first push on a full store also builds the heap.
// Throughput: one item at a time; the next starts the cycle after its result is popped.
// rst (synchronous) empties the store, clears the built flag, capacity 256, mode 0.
module bounded_top_k_heap_selector #(
  parameter int MAX_ENTRIES = 256,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          action,
  input  logic signed [DATA_WIDTH-1:0]        value,
  input  logic [btk_pkg::INDEX_WIDTH-1:0]     index,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [DATA_WIDTH-1:0]        read_value,
  output logic [btk_pkg::CAP_WIDTH-1:0]       entry_count,
  output logic                                kept,
  output logic                                index_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [btk_pkg::CAP_WIDTH-1:0]       cfg_data
);
  import btk_pkg::*;

  logic                        cmd_valid;
  logic                        cmd_take;
  logic [1:0]                  cmd_action;
  logic [DATA_WIDTH-1:0]       cmd_value;
  logic [INDEX_WIDTH-1:0]      cmd_index;
  logic [CAP_WIDTH-1:0]        capacity;
  logic                        order_mode;
  logic                        res_valid;
  logic [DATA_WIDTH-1:0]       res_value;

  // Config writes land whenever offered.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_WIDTH'(256);
      order_mode <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_CAPACITY) capacity <= cfg_data;
      else order_mode <= cfg_data[0];
    end
  end

  btk_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst, .push, .full, .action, .value, .index,
    .cmd_valid, .cmd_take, .cmd_action, .cmd_value, .cmd_index
  );

  btk_engine #(.MAX_ENTRIES(MAX_ENTRIES), .DATA_WIDTH(DATA_WIDTH)) u_engine (
    .clk, .rst, .cmd_valid, .cmd_take, .cmd_action, .cmd_value, .cmd_index,
    .capacity, .order_mode, .res_valid, .res_take(pop),
    .res_read_value(res_value), .res_entry_count(entry_count),
    .res_kept(kept), .res_index_valid(index_valid)
  );

  // Result register is the output beat; hold until popped.
  assign empty      = !res_valid;
  assign read_value = res_value;
endmodule

FILE: sim/bounded_top_k_heap_selector_test.sv
// Self-checking testbench for the bounded top-K heap selector.
`timescale 1ns / 1ps

module bounded_top_k_heap_selector_test;
  import btk_pkg::*;

  localparam int DEPTH       = 256;
  localparam int WATCHDOG    = 200000;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [8:0]         entry_count;
    logic               kept;
    logic               index_valid;
  } outcome_t;

  typedef struct {
    logic [1:0]         act;
    logic signed [31:0] val;
    logic [7:0]         idx;
    bit                 typed;     // expected outcome given in the row
    outcome_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [1:0] action = ACT_NOP;
  logic signed [31:0] value = '0;
  logic [7:0] index = '0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = REG_CAPACITY;
  logic [8:0] cfg_data = '0;
  logic full, empty, cfg_ready, kept, index_valid;
  logic signed [31:0] read_value;
  logic [8:0] entry_count;

  bounded_top_k_heap_selector dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .value(value), .index(index), .empty(empty), .pop(pop),
    .read_value(read_value), .entry_count(entry_count), .kept(kept),
    .index_valid(index_valid), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow state of the selector.
  logic signed [31:0] shadow_store [DEPTH];
  int unsigned shadow_count;
  bit          shadow_built;
  int unsigned shadow_cap;
  bit          shadow_largest;

  outcome_t pending_outcomes[$];
  int       error_count = 0;
  int       idle_cycles = 0;

  // Does a beat b under the current keep mode?
  function automatic bit outranks(logic signed [31:0] a, logic signed [31:0] b);
    return shadow_largest ? (a > b) : (a < b);
  endfunction

  function automatic void sift_from(int unsigned start);
    int unsigned pos, pick, lft;
    logic signed [31:0] t;
    pos = start;
    while (pos < shadow_count && pos < DEPTH) begin
      pick = pos;
      lft = 2 * pos + 1;
      if (lft < shadow_count) begin
        if (outranks(shadow_store[pick], shadow_store[lft])) pick = lft;
        if (lft + 1 < shadow_count && outranks(shadow_store[pick], shadow_store[lft + 1]))
          pick = lft + 1;
      end
      if (pick == pos) break;
      t = shadow_store[pos];
      shadow_store[pos] = shadow_store[pick];
      shadow_store[pick] = t;
      pos = pick;
    end
  endfunction

  // Apply one operation to the shadow state and return what the block reports.
  function automatic outcome_t select_step(logic [1:0] act, logic signed [31:0] val,
                                           logic [7:0] idx);
    outcome_t o;
    int unsigned k;
    o = '0;
    k = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (act)
      ACT_PUSH: begin
        if (k != 0) begin
          if (shadow_count < k) begin
            shadow_store[shadow_count] = val;
            shadow_count++;
            o.kept = 1'b1;
          end else begin
            if (!shadow_built) begin
              for (int i = k / 2; i > 0; i--) sift_from(i - 1);
              shadow_built = 1'b1;
            end
            if (outranks(val, shadow_store[0])) begin
              shadow_store[0] = val;
              sift_from(0);
              o.kept = 1'b1;
            end
          end
        end
      end
      ACT_READ: begin
        if (idx < shadow_count) begin
          o.read_value = shadow_store[idx];
          o.index_valid = 1'b1;
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        shadow_built = 1'b0;
      end
      default: ;
    endcase
    o.entry_count = shadow_count[8:0];
    return o;
  endfunction

  // Send one operation beat after an optional random gap; queue its expected outcome.
  task automatic send_op(logic [1:0] act, logic signed [31:0] val, logic [7:0] idx,
                         bit typed, outcome_t want, bit use_gap);
    outcome_t got;
    int unsigned gap;
    gap = use_gap ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    action <= act;
    value <= val;
    index <= idx;
    do @(posedge clk); while (full);
    @(negedge clk);
    got = select_step(act, val, idx);
    pending_outcomes.push_back(typed ? want : got);
  endtask

  // Write one register; waits until nothing is outstanding.
  task automatic write_reg(logic ridx, logic [8:0] data);
    push <= 1'b0;
    wait (pending_outcomes.size() == 0);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (ridx == REG_CAPACITY) shadow_cap = data;
    else shadow_largest = data[0];
  endtask

  // Random value: mostly narrow so duplicates and equal-to-root pushes occur.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 40)) - 20;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic random_burst(int n);
    logic [1:0] act;
    int unsigned r;
    outcome_t none;
    none = '0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) act = ACT_PUSH;
      else if (r < 90) act = ACT_READ;
      else if (r < 96) act = ACT_NOP;
      else act = ACT_CLEAR;
      send_op(act, pick_value(), 8'($urandom), 1'b0, none,
              (i % 64) < 48);  // leave stretches with no gaps
    end
  endtask

  // Directed table: expectations typed in only for obvious rows.
  function automatic stim_row_t row(logic [1:0] a, logic signed [31:0] v, logic [7:0] i,
                                    bit t, logic signed [31:0] rv, int cnt, bit kp, bit iv);
    stim_row_t s;
    s.act = a; s.val = v; s.idx = i; s.typed = t;
    s.want.read_value = rv; s.want.entry_count = cnt[8:0];
    s.want.kept = kp; s.want.index_valid = iv;
    return s;
  endfunction

  // Result side: random gap per beat, compare against the oldest expectation.
  initial begin
    outcome_t exp_o;
    int unsigned gap;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing expected");
        error_count++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (read_value !== exp_o.read_value) begin
          $error("read_value exp %0d got %0d", exp_o.read_value, read_value);
          error_count++;
        end
        if (entry_count !== exp_o.entry_count) begin
          $error("entry_count exp %0d got %0d", exp_o.entry_count, entry_count);
          error_count++;
        end
        if (kept !== exp_o.kept) begin
          $error("kept exp %0d got %0d", exp_o.kept, kept);
          error_count++;
        end
        if (index_valid !== exp_o.index_valid) begin
          $error("index_valid exp %0d got %0d", exp_o.index_valid, index_valid);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("bounded_top_k_heap_selector_test: errors");
      $finish;
    end
  end

  initial begin
    stim_row_t tbl[$];
    shadow_count = 0;
    shadow_built = 0;
    shadow_cap = 256;
    shadow_largest = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Small capacity, keep smallest.
    write_reg(REG_CAPACITY, 9'd3);
    tbl.push_back(row(ACT_READ, 0, 8'd0, 1, 0, 0, 0, 0));          // empty read
    tbl.push_back(row(ACT_NOP, 0, 8'd0, 1, 0, 0, 0, 0));           // unused code
    tbl.push_back(row(ACT_PUSH, 32'sh7fffffff, 0, 1, 0, 1, 1, 0));
    tbl.push_back(row(ACT_PUSH, 32'sh80000000, 0, 1, 0, 2, 1, 0));
    tbl.push_back(row(ACT_PUSH, 5, 0, 1, 0, 3, 1, 0));
    tbl.push_back(row(ACT_READ, 0, 8'd1, 1, 32'sh80000000, 3, 0, 1));
    tbl.push_back(row(ACT_READ, 0, 8'd255, 1, 0, 3, 0, 0));       // out of range
    tbl.push_back(row(ACT_PUSH, 7, 0, 0, 0, 0, 0, 0));              // builds heap
    tbl.push_back(row(ACT_PUSH, 5, 0, 0, 0, 0, 0, 0));              // equal to a stored entry
    tbl.push_back(row(ACT_PUSH, 32'sh7fffffff, 0, 0, 0, 0, 0, 0));
    tbl.push_back(row(ACT_READ, 0, 8'd0, 0, 0, 0, 0, 0));
    tbl.push_back(row(ACT_READ, 0, 8'd2, 0, 0, 0, 0, 0));
    tbl.push_back(row(ACT_CLEAR, 0, 0, 1, 0, 0, 0, 0));
    tbl.push_back(row(ACT_READ, 0, 8'd0, 1, 0, 0, 0, 0));         // cleared
    foreach (tbl[i]) send_op(tbl[i].act, tbl[i].val, tbl[i].idx, tbl[i].typed,
                             tbl[i].want, 1'b1);
    tbl.delete();

    // Capacity zero: pushes are dropped.
    write_reg(REG_CAPACITY, 9'd0);
    tbl.push_back(row(ACT_PUSH, -1, 0, 1, 0, 0, 0, 0));
    tbl.push_back(row(ACT_PUSH, 0, 0, 1, 0, 0, 0, 0));
    foreach (tbl[i]) send_op(tbl[i].act, tbl[i].val, tbl[i].idx, tbl[i].typed,
                             tbl[i].want, 1'b1);

    // Random phases over a spread of settings; raise and lower capacity mid-stream.
    write_reg(REG_ORDER_MODE, 9'd1);
    write_reg(REG_CAPACITY, 9'd5);
    random_burst(90);
    write_reg(REG_ORDER_MODE, 9'd0);   // stored order left as is
    random_burst(60);
    write_reg(REG_CAPACITY, 9'd2);     // below held count
    random_burst(60);
    write_reg(REG_CAPACITY, 9'd9);     // raised after build
    random_burst(80);
    write_reg(REG_CAPACITY, 9'd1);
    random_burst(50);
    write_reg(REG_CAPACITY, 9'd511);   // above depth, treated as full depth
    write_reg(REG_ORDER_MODE, 9'd1);
    random_burst(290);                 // long burst at full depth
    write_reg(REG_CAPACITY, 9'd256);
    write_reg(REG_ORDER_MODE, 9'd0);
    random_burst(30);

    push <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (100) @(negedge clk);
    if (error_count == 0)
      $display("bounded_top_k_heap_selector_test: clean");
    else
      $display("bounded_top_k_heap_selector_test: errors");
    $finish;
  end
endmodule
